/* design/route_message_stream_parser_macros.svh */
// assertion macros for the route message parser
`ifndef ROUTE_MESSAGE_STREAM_PARSER_MACROS_SVH
`define ROUTE_MESSAGE_STREAM_PARSER_MACROS_SVH

// implication checked every cycle outside reset
`define RMSP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmsp check failed");

// implication checked on the next cycle
`define RMSP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmsp check failed");

`endif

/* design/rmsp_pkg.sv */
// shared types and constants for the route message parser
package rmsp_pkg;

  localparam logic [15:0] MaxLenReset = 16'd4096;
  localparam logic [7:0]  VersionReset = 8'd4;
  localparam logic [7:0]  TransitiveFlag = 8'h40;

  localparam logic CfgMaxLen  = 1'b0;
  localparam logic CfgVersion = 1'b1;

  localparam logic [7:0] TypeOpen      = 8'd1;
  localparam logic [7:0] TypeUpdate    = 8'd2;
  localparam logic [7:0] TypeKeepalive = 8'd4;

  localparam logic [7:0] KindOrigin  = 8'd1;
  localparam logic [7:0] KindAsPath  = 8'd2;
  localparam logic [7:0] KindNextHop = 8'd3;

  localparam logic [3:0] PhHeader = 4'd0;
  localparam logic [3:0] PhWd0    = 4'd1;
  localparam logic [3:0] PhWd1    = 4'd2;
  localparam logic [3:0] PhAl0    = 4'd3;
  localparam logic [3:0] PhAl1    = 4'd4;
  localparam logic [3:0] PhFlags  = 4'd5;
  localparam logic [3:0] PhKind   = 4'd6;
  localparam logic [3:0] PhSize   = 4'd7;
  localparam logic [3:0] PhBody   = 4'd8;
  localparam logic [3:0] PhPrefix = 4'd9;
  localparam logic [3:0] PhDone   = 4'd10;
  localparam logic [3:0] PhIdle   = 4'd11;

  localparam int QueueDepth = 4;
  localparam int QueueAw = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    logic        message_valid;
    logic [7:0]  message_type;
    logic [15:0] payload_bytes;
    logic        update_valid;
    logic [15:0] origin_as;
    logic [31:0] next_hop_addr;
    logic [31:0] route_network;
    logic [5:0]  route_prefix_len;
    logic [31:0] route_mask;
  } out_beat_t;

  // classified beat passed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        frame_last;
    logic [15:0] pos;
    logic        in_hdr;
  } cls_beat_t;

endpackage

/* design/rmsp_front.sv */
// front part: byte position tracking and classification
module rmsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rmsp_pkg::in_beat_t  in_beat,
  output logic                cls_valid,
  input  logic                cls_ready,
  output rmsp_pkg::cls_beat_t cls_beat
);
  import rmsp_pkg::*;

  logic [15:0] byte_position;
  logic        take;

  assign full = ~cls_ready;
  assign take = push & cls_ready;
  assign cls_valid = push;

  always_comb begin
    cls_beat.data_byte  = in_beat.data_byte;
    cls_beat.frame_last = in_beat.frame_last;
    cls_beat.pos        = byte_position;
    cls_beat.in_hdr     = (byte_position < 16'd19);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (take) begin
      if (in_beat.frame_last) begin
        byte_position <= '0;
      end else if (byte_position != 16'hFFFF) begin
        byte_position <= byte_position + 16'd1;
      end
    end
  end

endmodule

/* design/rmsp_queue.sv */
// short queue between the front and back parts
module rmsp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  rmsp_pkg::cls_beat_t wr_beat,
  output logic                rd_valid,
  input  logic                rd_ready,
  output rmsp_pkg::cls_beat_t rd_beat
);
  import rmsp_pkg::*;

  cls_beat_t             slots [QueueDepth];
  logic [QueueAw-1:0]    wr_ptr;
  logic [QueueAw-1:0]    rd_ptr;
  logic [QueueAw:0]      count;
  logic                  do_wr;
  logic                  do_rd;

  assign wr_ready = (count != QueueAw'(0) + (QueueAw+1)'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_beat  = slots[rd_ptr];
  assign do_wr = wr_valid & wr_ready;
  assign do_rd = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + QueueAw'(1);
      if (do_rd) rd_ptr <= rd_ptr + QueueAw'(1);
      count <= count + (QueueAw+1)'(do_wr) - (QueueAw+1)'(do_rd);
    end
  end

endmodule

/* design/rmsp_back.sv */
// back part: header and update checks, result register
module rmsp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cls_valid,
  output logic                cls_ready,
  input  rmsp_pkg::cls_beat_t cls_beat,
  input  logic [15:0]         max_message_length,
  input  logic [7:0]          expected_version,
  output logic                empty,
  input  logic                pop,
  output rmsp_pkg::out_beat_t out_beat
);
  import rmsp_pkg::*;

  `include "route_message_stream_parser_macros.svh"

  logic [15:0] header_length, header_length_next;
  logic [7:0]  header_type, header_type_next;
  logic        header_error, header_error_next;
  logic        update_error, update_error_next;
  logic [3:0]  parse_phase, parse_phase_next;
  logic [15:0] attribute_end_pos, attribute_end_pos_next;
  logic [7:0]  attribute_flags, attribute_flags_next;
  logic [7:0]  attribute_kind, attribute_kind_next;
  logic [7:0]  attribute_remaining, attribute_remaining_next;
  logic [7:0]  attribute_index, attribute_index_next;
  logic [2:0]  seen_attributes, seen_attributes_next;
  logic [15:0] path_as, path_as_next;
  logic [31:0] hop_address, hop_address_next;
  logic [5:0]  prefix_bits, prefix_bits_next;
  logic [31:0] prefix_address, prefix_address_next;

  logic        out_full;
  out_beat_t   res;
  logic        take;
  logic [7:0]  b;
  logic [15:0] pos;
  logic [16:0] pos1, pos3, al_end, pf_end;
  logic [3:0]  octets;
  logic [16:0] count;
  logic        msg_ok, upd_ok;
  logic [31:0] mask;

  assign cls_ready = ~out_full | pop;
  assign take = cls_valid & cls_ready;
  assign empty = ~out_full;
  assign b = cls_beat.data_byte;
  assign pos = cls_beat.pos;
  assign pos1 = {1'b0, pos} + 17'd1;
  assign pos3 = {1'b0, pos} + 17'd3;
  assign al_end = 17'd23 + {1'b0, b, attribute_end_pos[7:0]};
  assign octets = 4'((b + 8'd7) >> 3);
  assign pf_end = pos1 + 17'(octets);

  always_comb begin
    header_length_next = header_length;
    header_type_next = header_type;
    header_error_next = header_error;
    update_error_next = update_error;
    parse_phase_next = parse_phase;
    attribute_end_pos_next = attribute_end_pos;
    attribute_flags_next = attribute_flags;
    attribute_kind_next = attribute_kind;
    attribute_remaining_next = attribute_remaining;
    attribute_index_next = attribute_index;
    seen_attributes_next = seen_attributes;
    path_as_next = path_as;
    hop_address_next = hop_address;
    prefix_bits_next = prefix_bits;
    prefix_address_next = prefix_address;
    if (cls_beat.in_hdr) begin
      if (pos < 16'd16) begin
        if (b != 8'hFF) header_error_next = 1'b1;
      end else if (pos == 16'd16) begin
        header_length_next = {8'd0, b};
      end else if (pos == 16'd17) begin
        header_length_next = {b, header_length[7:0]};
      end else begin
        header_type_next = b;
        parse_phase_next = (b == TypeUpdate) ? PhWd0 : PhIdle;
      end
    end else begin
      if (header_type == TypeOpen && pos == 16'd19 && b != expected_version)
        header_error_next = 1'b1;
      if (header_type == TypeOpen && pos == 16'd28 && b != 8'd0)
        header_error_next = 1'b1;
      if (pos < header_length) begin
        unique case (parse_phase)
          PhWd0, PhWd1: begin
            if (b != 8'd0) begin
              update_error_next = 1'b1;
              parse_phase_next = PhDone;
            end else begin
              parse_phase_next = parse_phase + 4'd1;
            end
          end
          PhAl0: begin
            attribute_end_pos_next = {8'd0, b};
            parse_phase_next = PhAl1;
          end
          PhAl1: begin
            if (al_end >= {1'b0, header_length}) begin
              update_error_next = 1'b1;
              parse_phase_next = PhDone;
            end else begin
              attribute_end_pos_next = al_end[15:0];
              parse_phase_next = PhFlags;
            end
          end
          PhFlags: begin
            if (pos == attribute_end_pos) begin
              if (b > 8'd32 || pf_end != {1'b0, header_length}) begin
                update_error_next = 1'b1;
                parse_phase_next = PhDone;
              end else begin
                prefix_bits_next = b[5:0];
                attribute_remaining_next = {4'd0, octets};
                attribute_index_next = '0;
                parse_phase_next = (octets != 4'd0) ? PhPrefix : PhDone;
              end
            end else if ({1'b0, attribute_end_pos} < pos3) begin
              update_error_next = 1'b1;
              parse_phase_next = PhDone;
            end else begin
              attribute_flags_next = b;
              parse_phase_next = PhKind;
            end
          end
          PhKind: begin
            attribute_kind_next = b;
            parse_phase_next = PhSize;
          end
          PhSize: begin
            if (({1'b0, attribute_end_pos} - pos1) < 17'(b)) begin
              update_error_next = 1'b1;
              parse_phase_next = PhDone;
            end else if (attribute_kind >= KindOrigin && attribute_kind <= KindNextHop &&
                         (attribute_flags != TransitiveFlag ||
                          b != ((attribute_kind == KindOrigin) ? 8'd1 : 8'd4))) begin
              update_error_next = 1'b1;
              parse_phase_next = PhDone;
            end else begin
              if (attribute_kind == KindOrigin)  seen_attributes_next[0] = 1'b1;
              if (attribute_kind == KindAsPath)  seen_attributes_next[1] = 1'b1;
              if (attribute_kind == KindNextHop) seen_attributes_next[2] = 1'b1;
              attribute_remaining_next = b;
              attribute_index_next = '0;
              parse_phase_next = (b != 8'd0) ? PhBody : PhFlags;
            end
          end
          PhBody: begin
            if ((attribute_kind == KindOrigin && b != 8'd0) ||
                (attribute_kind == KindAsPath && attribute_index == 8'd0 && b != 8'd2) ||
                (attribute_kind == KindAsPath && attribute_index == 8'd1 && b != 8'd1)) begin
              update_error_next = 1'b1;
              parse_phase_next = PhDone;
            end else begin
              if (attribute_kind == KindAsPath && attribute_index == 8'd2)
                path_as_next[7:0] = b;
              if (attribute_kind == KindAsPath && attribute_index == 8'd3)
                path_as_next[15:8] = b;
              if (attribute_kind == KindNextHop && attribute_index < 8'd4)
                hop_address_next[8*attribute_index[1:0] +: 8] = b;
              attribute_index_next = attribute_index + 8'd1;
              attribute_remaining_next = attribute_remaining - 8'd1;
              if (attribute_remaining == 8'd1) parse_phase_next = PhFlags;
            end
          end
          PhPrefix: begin
            if (attribute_index < 8'd4)
              prefix_address_next[8*attribute_index[1:0] +: 8] =
                prefix_address[8*attribute_index[1:0] +: 8] | b;
            attribute_index_next = attribute_index + 8'd1;
            attribute_remaining_next = attribute_remaining - 8'd1;
            if (attribute_remaining == 8'd1) parse_phase_next = PhDone;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    count = pos1;
    msg_ok = (count >= 17'd19) && !header_error_next && header_length_next >= 16'd19 &&
             header_length_next <= max_message_length &&
             {1'b0, header_length_next} <= count &&
             header_type_next >= TypeOpen && header_type_next <= TypeKeepalive &&
             (header_type_next != TypeKeepalive || header_length_next == 16'd19) &&
             (header_type_next != TypeOpen || header_length_next == 16'd29);
    upd_ok = msg_ok && header_type_next == TypeUpdate && !update_error_next &&
             parse_phase_next == PhDone && seen_attributes_next == 3'b111;
    mask = (prefix_bits_next == 6'd0 || prefix_bits_next > 6'd32) ? 32'd0 :
           (32'hFFFF_FFFF >> (6'd32 - prefix_bits_next));
    res.message_valid = msg_ok;
    res.message_type = (count >= 17'd19) ? header_type_next : 8'd0;
    res.payload_bytes = msg_ok ? header_length_next - 16'd19 : 16'd0;
    res.update_valid = upd_ok;
    res.origin_as = upd_ok ? path_as_next : 16'd0;
    res.next_hop_addr = upd_ok ? hop_address_next : 32'd0;
    res.route_network = upd_ok ? (prefix_address_next & mask) : 32'd0;
    res.route_prefix_len = upd_ok ? prefix_bits_next : 6'd0;
    res.route_mask = upd_ok ? mask : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && cls_beat.frame_last)) begin
      header_length <= '0;
      header_type <= '0;
      header_error <= 1'b0;
      update_error <= 1'b0;
      parse_phase <= PhHeader;
      attribute_end_pos <= '0;
      attribute_flags <= '0;
      attribute_kind <= '0;
      attribute_remaining <= '0;
      attribute_index <= '0;
      seen_attributes <= '0;
      path_as <= '0;
      hop_address <= '0;
      prefix_bits <= '0;
      prefix_address <= '0;
    end else if (take) begin
      header_length <= header_length_next;
      header_type <= header_type_next;
      header_error <= header_error_next;
      update_error <= update_error_next;
      parse_phase <= parse_phase_next;
      attribute_end_pos <= attribute_end_pos_next;
      attribute_flags <= attribute_flags_next;
      attribute_kind <= attribute_kind_next;
      attribute_remaining <= attribute_remaining_next;
      attribute_index <= attribute_index_next;
      seen_attributes <= seen_attributes_next;
      path_as <= path_as_next;
      hop_address <= hop_address_next;
      prefix_bits <= prefix_bits_next;
      prefix_address <= prefix_address_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (take && cls_beat.frame_last) begin
      out_full <= 1'b1;
    end else if (pop) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cls_beat.frame_last) out_beat <= res;
  end

  `RMSP_ASSERT_IMP(a_upd_implies_msg, out_full && out_beat.update_valid,
    out_beat.message_valid && out_beat.message_type == TypeUpdate)
  `RMSP_ASSERT_NXT(a_last_fills_output, take && cls_beat.frame_last, out_full)
  `RMSP_ASSERT_IMP(a_stall_only_when_full, !cls_ready, out_full)
  `RMSP_ASSERT_NXT(a_held_result, out_full && !pop, out_full && $stable(out_beat))

endmodule

/* design/route_message_stream_parser.sv */
// top level of the route message stream parser
//  channel | handshake        | payload
//  input   | push / full      | in_beat (data_byte, frame_last)
//  result  | empty / pop      | out_beat, one per frame on its last byte
//  config  | cfg_valid / ready| cfg_index, cfg_data
// one byte a cycle sustained while the back part does not stall; a last beat
// passes through front, queue, and back with its result register
// the back part stalls only while the result register holds an untaken beat
// reset clears the queue, the parse state and the registers to their defaults
module route_message_stream_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  rmsp_pkg::in_beat_t  in_beat,
  output logic                empty,
  input  logic                pop,
  output rmsp_pkg::out_beat_t out_beat,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_data
);
  import rmsp_pkg::*;

  logic [15:0] max_message_length;
  logic [7:0]  expected_version;
  logic        f_valid, f_ready, b_valid, b_ready;
  cls_beat_t   f_beat, b_beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= MaxLenReset;
      expected_version <= VersionReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgMaxLen:  max_message_length <= cfg_data;
        CfgVersion: expected_version <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  rmsp_front u_front (
    .clk, .rst, .push, .full, .in_beat,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_beat(f_beat)
  );

  rmsp_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_beat(f_beat),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_beat(b_beat)
  );

  rmsp_back u_back (
    .clk, .rst,
    .cls_valid(b_valid), .cls_ready(b_ready), .cls_beat(b_beat),
    .max_message_length, .expected_version,
    .empty, .pop, .out_beat
  );

endmodule
